### design/hmd5_pkg.sv
// Package with shared types, constants and MD5 tables for the HMAC-MD5 generator.
package hmd5_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int KEY_WORDS = 8;
    localparam int ADDR_W = 6;

    localparam logic [31:0] IPAD_WORD = 32'h36363636;
    localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
    localparam logic [31:0] MSG_BITS = 32'd640;
    localparam logic [31:0] PAD_WORD = 32'h00000080;

    localparam logic [127:0] MD5_IV =
        {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_ADD,
        ST_OUT
    } state_t;

    // Which message block the datapath compresses next.
    typedef enum logic [1:0] {
        SEL_IKEY,
        SEL_IMSG,
        SEL_OKEY,
        SEL_OMSG
    } blk_sel_t;

    typedef struct packed {
        logic     start_req;
        logic     init_chain;
        logic     load_blk;
        blk_sel_t sel;
        logic     round_en;
        logic     add_en;
        logic     save_inner;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic rounds_done;
        logic out_full;
        logic req_last;
    } dp_sts_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;   6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;   6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;   6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;   6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;   6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd7;
            endcase
            return s;
        end
    endfunction

endpackage

### design/hmac_md5_counter_prng_unit.sv
// Top level of the HMAC-MD5 counter-mode random generator.
// Each request yields ceil(byte_count/16) results, at most MAX_BLOCKS; every result costs
// four MD5 compressions on one shared round unit of one round per cycle. A request is
// taken only when the previous one has produced all of its results; a request of zero
// bytes emits nothing.
module hmac_md5_counter_prng_unit #(
    parameter int MAX_BLOCKS = hmd5_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hmd5_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [79:0]                   s_tdata,  // time_stamp[63:0], byte_count[74:64]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [135:0]                  m_tdata,  // digest_low, digest_high, valid_bytes
    output logic                          m_tlast,
    output logic                          m_tuser   // truncated
);
    import hmd5_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    idle, in_fire, out_fire, cfg_we, zero_req;
    logic [63:0] dl, dh;
    logic [4:0]  vb;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && (paddr[2:0] == 3'd0);
    assign s_tready = idle;
    assign zero_req = (s_tdata[74:64] == 11'd0);
    assign in_fire  = s_tvalid && s_tready && !zero_req;
    assign out_fire = m_tvalid && m_tready;
    assign m_tdata  = {3'b000, vb, dh, dl};

    hmd5_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    hmd5_dpath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_idx     (paddr[5:3]),
        .cfg_data    (pwdata),
        .cfg_rdata   (prdata),
        .time_stamp  (s_tdata[63:0]),
        .byte_count  (s_tdata[74:64]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .digest_low  (dl),
        .digest_high (dh),
        .valid_bytes (vb),
        .last_block  (m_tlast),
        .truncated   (m_tuser)
    );

endmodule

### design/hmd5_ctrl.sv
// Controller state machine sequencing the four compressions of each block.
module hmd5_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  hmd5_pkg::dp_sts_t sts,
    output hmd5_pkg::dp_cmd_t cmd,
    output logic              idle
);
    import hmd5_pkg::*;

    state_t   state_reg, state_next;
    blk_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_IKEY;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOAD;
                    sel_next   = SEL_IKEY;
                end
            end
            ST_LOAD: state_next = ST_RUN;
            ST_RUN:
            begin
                if (sts.rounds_done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                case (sel_reg)
                    SEL_IKEY: sel_next = SEL_IMSG;
                    SEL_IMSG: sel_next = SEL_OKEY;
                    SEL_OKEY: sel_next = SEL_OMSG;
                    default:  sel_next = SEL_IKEY;
                endcase
                state_next = (sel_reg == SEL_OMSG) ? ST_OUT : ST_LOAD;
            end
            ST_OUT:
            begin
                if (!sts.out_full || out_fire)
                begin
                    state_next = sts.req_last ? ST_IDLE : ST_LOAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.sel        = sel_reg;
        cmd.start_req  = (state_reg == ST_IDLE) && in_fire;
        cmd.init_chain = (state_reg == ST_LOAD) &&
                         (sel_reg == SEL_IKEY || sel_reg == SEL_OKEY);
        cmd.load_blk   = (state_reg == ST_LOAD);
        cmd.round_en   = (state_reg == ST_RUN);
        cmd.add_en     = (state_reg == ST_ADD);
        cmd.save_inner = (state_reg == ST_ADD) && (sel_reg == SEL_IMSG);
        cmd.emit       = (state_reg == ST_OUT) && (!sts.out_full || out_fire);
    end

    assign idle = (state_reg == ST_IDLE);

`ifndef SYNTHESIS
    a_load_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_fire) |=> (state_reg == ST_LOAD))
        else $error("request did not start a block");
    a_run_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_RUN))
        else $error("load not followed by rounds");
    a_emit_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (sel_reg == SEL_IKEY))
        else $error("emit outside final compression");
`endif

endmodule

### design/hmd5_dpath.sv
// Datapath with key registers, the MD5 round unit, counter and output register.
module hmd5_dpath #(
    parameter int MAX_BLOCKS = hmd5_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  hmd5_pkg::dp_cmd_t          cmd,
    output hmd5_pkg::dp_sts_t          sts,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_idx,
    input  logic [63:0]                cfg_data,
    output logic [63:0]                cfg_rdata,
    input  logic [63:0]                time_stamp,
    input  logic [10:0]                byte_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [63:0]                digest_low,
    output logic [63:0]                digest_high,
    output logic [4:0]                 valid_bytes,
    output logic                       last_block,
    output logic                       truncated
);
    import hmd5_pkg::*;

    localparam int BW = $clog2(MAX_BLOCKS + 1);

    logic [63:0]  key_reg [KEY_WORDS];
    logic [63:0]  ctr_reg;
    logic [63:0]  stamp_reg;
    logic [10:0]  rem_reg;
    logic [BW-1:0] blk_left_reg;
    logic         trunc_reg;
    logic [127:0] chain_reg;
    logic [127:0] inner_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  m_reg [16];
    logic [5:0]   rnd_reg;
    logic         ov_reg;
    logic [63:0]  dl_reg, dh_reg;
    logic [4:0]   vb_reg;
    logic         lb_reg, tr_reg;

    logic [31:0]  f, g_word, sum, rot;
    logic [3:0]   g;
    logic [4:0]   s;
    logic [7:0]   need;
    logic [31:0]  blk [16];
    logic [31:0]  pad;
    logic [127:0] add_res;

    assign cfg_rdata = key_reg[cfg_idx];

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0: begin f = (b_reg & c_reg) | (~b_reg & d_reg); g = rnd_reg[3:0]; end
            2'd1: begin f = (d_reg & b_reg) | (~d_reg & c_reg);
                        g = 4'(rnd_reg * 3'd5 + 1'b1); end
            2'd2: begin f = b_reg ^ c_reg ^ d_reg; g = 4'(rnd_reg * 2'd3 + 3'd5); end
            default: begin f = c_reg ^ (b_reg | ~d_reg); g = 4'(rnd_reg * 3'd7); end
        endcase
        g_word = m_reg[g];
        s      = md5_s(rnd_reg);
        sum    = f + a_reg + md5_k(rnd_reg) + g_word;
        rot    = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    always_comb
    begin
        pad = (cmd.sel == SEL_IKEY) ? IPAD_WORD : OPAD_WORD;
        for (int j = 0; j < 16; j++)
        begin
            blk[j] = '0;
        end
        case (cmd.sel)
            SEL_IKEY, SEL_OKEY:
            begin
                for (int j = 0; j < 16; j++)
                begin
                    blk[j] = key_reg[j/2][32*(j%2) +: 32] ^ pad;
                end
            end
            SEL_IMSG:
            begin
                blk[0] = stamp_reg[31:0];
                blk[1] = stamp_reg[63:32];
                blk[2] = ctr_reg[31:0];
                blk[3] = ctr_reg[63:32];
                blk[4] = PAD_WORD;
                blk[14] = MSG_BITS;
            end
            default:
            begin
                blk[0] = inner_reg[31:0];
                blk[1] = inner_reg[63:32];
                blk[2] = inner_reg[95:64];
                blk[3] = inner_reg[127:96];
                blk[4] = PAD_WORD;
                blk[14] = MSG_BITS;
            end
        endcase
        add_res = {chain_reg[127:96] + d_reg, chain_reg[95:64] + c_reg,
                   chain_reg[63:32] + b_reg, chain_reg[31:0] + a_reg};
    end

    assign need = 8'((12'(byte_count) + 12'd15) >> 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < KEY_WORDS; j++)
            begin
                key_reg[j] <= '0;
            end
            ctr_reg <= '0;
            ov_reg  <= 1'b0;
            rnd_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_reg[cfg_idx] <= cfg_data;
            end
            if (cmd.load_blk)
            begin
                rnd_reg <= '0;
            end
            else if (cmd.round_en)
            begin
                rnd_reg <= rnd_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                ctr_reg <= ctr_reg + 1'b1;
                ov_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_req)
        begin
            stamp_reg <= time_stamp;
            rem_reg   <= byte_count;
            if (need > 8'(MAX_BLOCKS))
            begin
                blk_left_reg <= BW'(MAX_BLOCKS);
                trunc_reg    <= 1'b1;
            end
            else
            begin
                blk_left_reg <= BW'(need);
                trunc_reg    <= 1'b0;
            end
        end
        if (cmd.load_blk)
        begin
            for (int j = 0; j < 16; j++)
            begin
                m_reg[j] <= blk[j];
            end
            if (cmd.init_chain)
            begin
                chain_reg <= MD5_IV;
                {d_reg, c_reg, b_reg, a_reg} <= MD5_IV;
            end
            else
            begin
                {d_reg, c_reg, b_reg, a_reg} <= chain_reg;
            end
        end
        else if (cmd.round_en)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
        if (cmd.add_en)
        begin
            chain_reg <= add_res;
            if (cmd.save_inner)
            begin
                inner_reg <= add_res;
            end
        end
        if (cmd.emit)
        begin
            dl_reg <= chain_reg[63:0];
            dh_reg <= chain_reg[127:64];
            lb_reg <= (blk_left_reg == BW'(1));
            tr_reg <= trunc_reg;
            vb_reg <= (!trunc_reg && rem_reg < 11'd16) ? 5'(rem_reg) : 5'd16;
            rem_reg <= rem_reg - 11'd16;
            blk_left_reg <= blk_left_reg - 1'b1;
        end
    end

    assign sts.rounds_done = (rnd_reg == 6'd63);
    assign sts.out_full    = ov_reg;
    assign sts.req_last    = (blk_left_reg == BW'(1));

    assign out_valid   = ov_reg;
    assign digest_low  = dl_reg;
    assign digest_high = dh_reg;
    assign valid_bytes = vb_reg;
    assign last_block  = lb_reg;
    assign truncated   = tr_reg;

`ifndef SYNTHESIS
    a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (ctr_reg == $past(ctr_reg) + 64'd1))
        else $error("counter did not advance");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready && !cmd.emit) |=> ov_reg)
        else $error("result dropped");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!ov_reg || out_ready))
        else $error("result overwritten");
`endif

endmodule
